// ===== rtl/kmce_pkg.sv =====
// shared types, constants and code table of the key matrix code encoder
package kmce_pkg;

  localparam int ROW_COUNT = 9;
  localparam int COL_COUNT = 10;
  localparam int ROW_W = 4;
  localparam int COL_W = 4;
  localparam int IDX_W = 8;
  localparam int CODE_W = 8;
  localparam int ROM_DEPTH = 181;
  localparam int IN_DATA_W = 96;
  localparam int OUT_DATA_W = 16;

  localparam logic [CODE_W-1:0] CTRL_MASK = 8'hbf;
  localparam logic [CODE_W-1:0] KANA_BIT = 8'h80;
  localparam logic [IDX_W-1:0] LAST_IDX = 8'd180;

  typedef struct packed {
    logic             hit;
    logic [COL_W-1:0] col;
  } lane_t;

  typedef struct packed {
    logic              pressed;
    logic [CODE_W-1:0] code;
  } result_t;

  localparam logic [CODE_W-1:0] CODE_ROM [0:ROM_DEPTH-1] = '{
    8'h00,
    8'h1b, 8'h1b, 8'h7c, 8'h7c, 8'h18, 8'h18, 8'h0f, 8'h0f, 8'h09, 8'h09,
    8'h1c, 8'h1c, 8'h30, 8'h00, 8'h50, 8'h70, 8'h3b, 8'h2b,
    8'h00, 8'h00, 8'h31, 8'h21, 8'h51, 8'h71, 8'h41, 8'h61, 8'h5a, 8'h7a,
    8'h17, 8'h17, 8'h2d, 8'h3d, 8'h40, 8'h60, 8'h3a, 8'h2a,
    8'h0b, 8'h0b, 8'h32, 8'h22, 8'h57, 8'h77, 8'h53, 8'h73, 8'h58, 8'h78,
    8'h03, 8'h03, 8'h5e, 8'h7e, 8'h5b, 8'h7b, 8'h5d, 8'h7d,
    8'h1f, 8'h1f, 8'h33, 8'h23, 8'h45, 8'h65, 8'h44, 8'h64, 8'h43, 8'h63,
    8'h0c, 8'h0c, 8'h5c, 8'h7c, 8'h0a, 8'h0a, 8'h00, 8'h00,
    8'h01, 8'h01, 8'h34, 8'h24, 8'h52, 8'h72, 8'h46, 8'h66, 8'h56, 8'h76,
    8'h04, 8'h04, 8'h7f, 8'h7f, 8'h08, 8'h08, 8'h0e, 8'h0e,
    8'h02, 8'h02, 8'h35, 8'h25, 8'h54, 8'h74, 8'h47, 8'h67, 8'h42, 8'h62,
    8'h75, 8'h75, 8'h64, 8'h64, 8'h00, 8'h00, 8'h20, 8'h20,
    8'h1e, 8'h1e, 8'h36, 8'h26, 8'h59, 8'h79, 8'h48, 8'h68, 8'h4e, 8'h6e,
    8'h37, 8'h37, 8'h34, 8'h34, 8'h31, 8'h31, 8'h30, 8'h30,
    8'h1d, 8'h1d, 8'h37, 8'h27, 8'h55, 8'h75, 8'h4a, 8'h6a, 8'h4d, 8'h6d,
    8'h38, 8'h38, 8'h35, 8'h35, 8'h32, 8'h32, 8'h11, 8'h11,
    8'h0d, 8'h0d, 8'h38, 8'h28, 8'h49, 8'h69, 8'h4b, 8'h6b, 8'h2c, 8'h3c,
    8'h39, 8'h39, 8'h36, 8'h36, 8'h33, 8'h33, 8'h12, 8'h12,
    8'h07, 8'h07, 8'h39, 8'h29, 8'h4f, 8'h6f, 8'h4c, 8'h6c, 8'h2e, 8'h3e,
    8'h63, 8'h63, 8'h66, 8'h66, 8'h61, 8'h61, 8'h2f, 8'h3f
  };

endpackage

// ===== rtl/kmce_lane.sv =====
// per-row lane: finds the highest pressed column of one matrix row
module kmce_lane (
  input  logic [kmce_pkg::COL_COUNT-1:0] bits,
  output kmce_pkg::lane_t                result
);

  always_comb begin
    result.hit = |bits;
    result.col = '0;
    for (int c = 0; c < kmce_pkg::COL_COUNT; c++) begin
      if (bits[c]) begin
        result.col = kmce_pkg::COL_W'(c);
      end
    end
  end

endmodule

// ===== rtl/kmce_merge.sv =====
// merge stage: picks the winning row, looks up the code, applies modifiers, holds the code
module kmce_merge (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    accept,
  input  kmce_pkg::lane_t [kmce_pkg::ROW_COUNT-1:0] lanes,
  input  logic                                    ctrl_down,
  input  logic                                    shift_down,
  input  logic                                    kana_down,
  output kmce_pkg::result_t                       result
);

  logic [kmce_pkg::CODE_W-1:0] held_code;
  logic [kmce_pkg::CODE_W-1:0] held_code_next;
  logic                        any;
  logic [kmce_pkg::ROW_W-1:0]  win_row;
  logic [kmce_pkg::COL_W-1:0]  win_col;
  logic [kmce_pkg::IDX_W-1:0]  base;
  logic [kmce_pkg::IDX_W-1:0]  idx;
  logic [kmce_pkg::IDX_W-1:0]  rom_idx;
  logic [kmce_pkg::CODE_W-1:0] code;

  // last hit row in scan order wins
  always_comb begin
    any = 1'b0;
    win_row = '0;
    win_col = '0;
    for (int r = 0; r < kmce_pkg::ROW_COUNT; r++) begin
      if (lanes[r].hit) begin
        any = 1'b1;
        win_row = kmce_pkg::ROW_W'(r);
        win_col = lanes[r].col;
      end
    end
  end

  // index = (row + col*9)*2 + shift + 1
  always_comb begin
    base = {4'b0, win_row} + {1'b0, win_col, 3'b0} + {4'b0, win_col};
    idx = {base[6:0], 1'b0} + {7'b0, shift_down} + 8'd1;
    rom_idx = (idx <= kmce_pkg::LAST_IDX) ? idx : '0;
    code = kmce_pkg::CODE_ROM[rom_idx];
    if (ctrl_down) begin
      code = code & kmce_pkg::CTRL_MASK;
    end
    if (kana_down) begin
      code = code | kmce_pkg::KANA_BIT;
    end
    held_code_next = any ? code : held_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_code <= '0;
    end else if (accept) begin
      held_code <= held_code_next;
    end
  end

  assign result.pressed = any;
  assign result.code = held_code_next;

endmodule

// ===== rtl/kmce_out.sv =====
// two-entry output register with skid slot
module kmce_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kmce_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kmce_pkg::result_t out_data
);

  logic              skid_valid;
  kmce_pkg::result_t skid_data;
  logic              accept;
  logic              load_out;

  assign in_ready = !skid_valid;
  assign accept = in_valid && in_ready;
  assign load_out = out_ready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (accept) begin
      skid_data <= in_data;
    end
  end

endmodule

// ===== rtl/key_matrix_code_encoder_core.sv =====
// top level of the key matrix code encoder
// Takes one full matrix scan per clock while s_axis_tready is high and returns
// one item per scan: nine row lanes find the highest pressed column of each row in
// parallel, a merge stage picks the highest pressed row, forms the table index and
// looks up the code in the same cycle, and a two-entry output register lets a new
// scan in while an earlier result still waits. When no key is pressed the held code
// is repeated with key_pressed low and the modifiers are ignored.
module key_matrix_code_encoder_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // row_zero .. row_eight (10 bits each), ctrl_down, shift_down, kana_down, zero pad
  input  logic [kmce_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // key_code (8 bits), key_pressed, zero pad
  output logic [kmce_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  kmce_pkg::lane_t [kmce_pkg::ROW_COUNT-1:0] lanes;
  kmce_pkg::result_t                        result;
  kmce_pkg::result_t                        out_data;
  logic                                     accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  for (genvar r = 0; r < kmce_pkg::ROW_COUNT; r++) begin : g_lane
    kmce_lane u_lane (
      .bits   (s_axis_tdata[r*kmce_pkg::COL_COUNT +: kmce_pkg::COL_COUNT]),
      .result (lanes[r])
    );
  end

  kmce_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .lanes      (lanes),
    .ctrl_down  (s_axis_tdata[90]),
    .shift_down (s_axis_tdata[91]),
    .kana_down  (s_axis_tdata[92]),
    .result     (result)
  );

  kmce_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (result),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {7'b0, out_data.pressed, out_data.code};

endmodule

// ===== rtl/kmce_checker.sv =====
// port-level checker of the key matrix code encoder, bound to the top level
module kmce_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  logic [7:0] last_code;

  // code of the last delivered item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_code <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      last_code <= m_axis_tdata[7:0];
    end
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_no_key_keeps_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == last_code)
    else $error("held code changed without a key press");

  a_full_means_pending: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input blocked with no item pending");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:9] == 7'b0)
    else $error("output pad bits not zero");

endmodule

bind key_matrix_code_encoder_core kmce_checker u_kmce_checker (.*);
